/* sv/sklu_pkg.sv */
// shared types and constants for the sorted key list unit
// record layout, request and status codes, cell control bundle
// no dependencies
package sklu_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int PRICE_W      = 32;
    localparam int POS_W        = 6;
    localparam int TOTAL_W      = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_READ   = 2'd2,
        REQ_DUMP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_READ,
        SCAN_DUMP
    } t_scan_mode;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    kind;
        logic [PRICE_W-1:0]      price;
    } t_rec;

    typedef struct packed {
        logic             ins_en;
        logic             scan_load;
        logic             scan_shift;
        t_scan_mode       mode;
        t_rec             new_rec;
        logic [POS_W-1:0] position;
    } t_cell_ctrl;

endpackage

/* sv/sklu_cell.sv */
// one cell of the sorted record chain: a stored record plus a scan stage
// depends on sklu_pkg
module sklu_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  sklu_pkg::t_cell_ctrl i_ctrl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic                i_left_ins,
    input  sklu_pkg::t_rec      i_left_rec,
    output logic                o_ins,
    output sklu_pkg::t_rec      o_rec,
    input  sklu_pkg::t_rec      i_right_scan_rec,
    input  logic                i_right_scan_hit,
    output sklu_pkg::t_rec      o_scan_rec,
    output logic                o_scan_hit
);
    import sklu_pkg::*;

    t_rec r_rec;
    t_rec r_scan_rec;
    logic r_scan_hit;
    logic occupied;
    logic hit;

    // a free cell or one whose key sorts after the new key takes part in the insert
    assign occupied = CNT_W'(IDX) < i_count;
    assign o_ins    = !occupied || (r_rec.key > i_ctrl.new_rec.key);
    assign o_rec    = r_rec;

    always_comb begin
        case (i_ctrl.mode)
            SCAN_FIND: hit = (r_rec.key == i_ctrl.new_rec.key);
            SCAN_READ: hit = (POS_W'(IDX) == i_ctrl.position);
            default:   hit = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && o_ins) begin
            r_rec <= i_left_ins ? i_left_rec : i_ctrl.new_rec;
        end
        if (i_ctrl.scan_load) begin
            r_scan_rec <= r_rec;
            r_scan_hit <= hit;
        end else if (i_ctrl.scan_shift) begin
            r_scan_rec <= i_right_scan_rec;
            r_scan_hit <= i_right_scan_hit;
        end
    end

    assign o_scan_rec = r_scan_rec;
    assign o_scan_hit = r_scan_hit;

endmodule

/* sv/sorted_key_list_unit.sv */
// sorted key list unit: one request at a time, next request beat taken in the cycle after
// the final result beat is loaded; insert and unscanned answers are given from the exec state
// a scan (find, read, dump) loads the scan line, then shifts it toward the head
// (one cell per cycle, up to the count); dump streams one beat per cycle unstalled
// a finished beat may wait in the output register
// synchronous active-low reset clears the record count and the handshake state
module sorted_key_list_unit #(
    parameter int CAPACITY = sklu_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_req_type,
    input  logic signed [sklu_pkg::KEY_W-1:0]    i_key,
    input  logic                                 i_kind,
    input  logic [sklu_pkg::PRICE_W-1:0]         i_price_bits,
    input  logic [sklu_pkg::POS_W-1:0]           i_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_status,
    output logic signed [sklu_pkg::KEY_W-1:0]    o_rec_key,
    output logic                                 o_rec_kind,
    output logic [sklu_pkg::PRICE_W-1:0]         o_rec_price,
    output logic [sklu_pkg::TOTAL_W-1:0]         o_entry_total,
    output logic                                 o_last
);
    import sklu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;

    // latched request beat
    t_req             r_req_type;
    t_rec             r_req_rec;
    logic [POS_W-1:0] r_req_pos;

    // output register
    logic             r_out_valid;
    t_status          r_out_status;
    t_rec             r_out_rec;
    logic [CNT_W-1:0] r_out_total;
    logic             r_out_last;

    // chain wiring
    t_rec       cell_rec  [CAPACITY];
    logic       cell_ins  [CAPACITY];
    t_rec       scan_rec  [CAPACITY];
    logic       scan_hit  [CAPACITY];
    t_cell_ctrl ctrl;

    logic out_free;
    logic out_load;
    logic full;
    logic pos_out;
    logic at_end;
    logic last_el;
    logic is_dump;

    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_count == CNT_W'(CAPACITY));
    // read beyond the count is answered without scanning
    assign pos_out  = TOTAL_W'(r_req_pos) >= TOTAL_W'(r_count);
    // scan ran past the last held record
    assign at_end   = (r_idx == r_count);
    assign last_el  = ((r_idx + CNT_W'(1)) == r_count);
    assign is_dump  = (r_req_type == REQ_DUMP);

    // output register takes a beat this cycle
    assign out_load = out_free &&
        ((r_state == S_EXEC && (r_req_type == REQ_INSERT || r_count == '0 ||
                                (r_req_type == REQ_READ && pos_out))) ||
         (r_state == S_SCAN && (at_end || scan_hit[0])));

    // cell control: shared by every cell of the chain
    always_comb begin
        ctrl            = '0;
        ctrl.new_rec    = r_req_rec;
        ctrl.position   = r_req_pos;
        case (r_req_type)
            REQ_READ: ctrl.mode = SCAN_READ;
            REQ_DUMP: ctrl.mode = SCAN_DUMP;
            default:  ctrl.mode = SCAN_FIND;
        endcase
        unique case (r_state)
            S_EXEC: begin
                if (r_req_type == REQ_INSERT) begin
                    ctrl.ins_en = out_free && !full;
                end else if (r_count != '0 && !(r_req_type == REQ_READ && pos_out)) begin
                    ctrl.scan_load = 1'b1;
                end
            end
            S_SCAN: begin
                // step past a miss, or past a dumped record that is not the last
                if (!at_end) begin
                    ctrl.scan_shift = !scan_hit[0] ||
                                      (out_free && is_dump && !last_el);
                end
            end
            default: begin
            end
        endcase
    end

    // the cell chain: insert shifts records one cell right, scan line shifts left
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec left_rec;
        logic left_ins;
        t_rec right_scan_rec;
        logic right_scan_hit;

        if (g == 0) begin : g_head
            assign left_rec = r_req_rec;
            assign left_ins = 1'b0;
        end else begin : g_body
            assign left_rec = cell_rec[g-1];
            assign left_ins = cell_ins[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_scan_rec = '0;
            assign right_scan_hit = 1'b0;
        end else begin : g_inner
            assign right_scan_rec = scan_rec[g+1];
            assign right_scan_hit = scan_hit[g+1];
        end

        sklu_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk            (i_clk),
            .i_ctrl           (ctrl),
            .i_count          (r_count),
            .i_left_ins       (left_ins),
            .i_left_rec       (left_rec),
            .o_ins            (cell_ins[g]),
            .o_rec            (cell_rec[g]),
            .i_right_scan_rec (right_scan_rec),
            .i_right_scan_hit (right_scan_hit),
            .o_scan_rec       (scan_rec[g]),
            .o_scan_hit       (scan_hit[g])
        );
    end

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req_type      <= t_req'(i_req_type);
                        r_req_rec.key   <= i_key;
                        r_req_rec.kind  <= i_kind;
                        r_req_rec.price <= i_price_bits;
                        r_req_pos       <= i_position;
                        r_state         <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_req_type == REQ_INSERT) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_last  <= 1'b1;
                            r_state     <= S_IDLE;
                            if (full) begin
                                // dropped insert, list unchanged
                                r_out_status <= ST_FULL;
                                r_out_rec    <= '0;
                                r_out_total  <= r_count;
                            end else begin
                                r_out_status <= ST_OK;
                                r_out_rec    <= r_req_rec;
                                r_out_total  <= r_count + CNT_W'(1);
                                r_count      <= r_count + CNT_W'(1);
                            end
                        end
                    end else if (r_count == '0) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_EMPTY;
                            r_out_rec    <= '0;
                            r_out_total  <= r_count;
                            r_out_last   <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end else if (r_req_type == REQ_READ && pos_out) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_NOTFOUND;
                            r_out_rec    <= '0;
                            r_out_total  <= r_count;
                            r_out_last   <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        // scan line loaded this cycle
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (at_end) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_NOTFOUND;
                            r_out_rec    <= '0;
                            r_out_total  <= r_count;
                            r_out_last   <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end else if (scan_hit[0]) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_OK;
                            r_out_rec    <= scan_rec[0];
                            r_out_total  <= r_count;
                            r_out_last   <= !is_dump || last_el;
                            if (!is_dump || last_el) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_idx <= r_idx + CNT_W'(1);
                            end
                        end
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_rec_key     = r_out_rec.key;
    assign o_rec_kind    = r_out_rec.kind;
    assign o_rec_price   = r_out_rec.price;
    assign o_entry_total = TOTAL_W'(r_out_total);
    assign o_last        = r_out_last;

endmodule
